@@ hdl/ddc_pkg.sv @@
`default_nettype none

package ddc_pkg;

  // Configuration port geometry: seven 32-bit registers at word addresses.
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned RegIdxW  = CfgAddrW - 2;

  // Register indexes.
  localparam logic [RegIdxW-1:0] REG_TRACK_WIDTH    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_SPEED_LIMIT    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_LEFT_MOTOR_ID  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_RIGHT_MOTOR_ID = 3'd3;
  localparam logic [RegIdxW-1:0] REG_DUTY_GAIN      = 3'd4;
  localparam logic [RegIdxW-1:0] REG_PERIOD_TICKS   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_TIMEOUT_TICKS  = 3'd6;

  // Input action codes.
  localparam logic [1:0] ACT_COMMAND   = 2'd0;
  localparam logic [1:0] ACT_HEARTBEAT = 2'd1;
  localparam logic [1:0] ACT_TICK      = 2'd2;

  // Frame and arithmetic constants.
  localparam logic [31:0] EFF_FLAG   = 32'h8000_0000;
  localparam logic [3:0]  DATA_LEN   = 4'd4;
  localparam logic [16:0] DUTY_LIMIT = 17'd100000;
  localparam logic [16:0] AGE_MAX    = 17'h1_FFFF;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [4:0]  MUL_LAST   = 5'd31;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame_id;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic        last_frame;
  } out_frame_t;

  typedef struct packed {
    logic [19:0] track_width;
    logic [30:0] speed_limit;
    logic [28:0] left_motor_id;
    logic [28:0] right_motor_id;
    logic [31:0] duty_gain;
    logic [15:0] period_ticks;
    logic [15:0] timeout_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    track_width:    20'd24248,
    speed_limit:    31'd131072,
    left_motor_id:  29'd28,
    right_motor_id: 29'd46,
    duty_gain:      32'd834109709,
    period_ticks:   16'd20,
    timeout_ticks:  16'd500
  };

  // Request to the bit-serial multiplier and its answer.
  typedef struct packed {
    logic        start;
    logic [31:0] mcand;
    logic [31:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  // Frame handed to the output register.
  typedef struct packed {
    logic       push;
    out_frame_t frame;
  } push_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HALF,
    S_LEFT,
    S_RIGHT,
    S_MUL_L,
    S_PUSH_L,
    S_MUL_R,
    S_PUSH_R
  } seq_state_t;

endpackage

`default_nettype wire

@@ hdl/ddc_sermul.sv @@
`default_nettype none

// Unsigned 32 x 32 shift-and-add multiplier, one multiplier bit per cycle.
module ddc_sermul (
  input  logic              clk,
  input  logic              rst_n,
  input  ddc_pkg::mul_req_t req,
  output ddc_pkg::mul_rsp_t rsp
);
  import ddc_pkg::*;

  logic [31:0] mcand_r, mcand_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sum;

  // One partial product per cycle; the low half shifts out the multiplier bits
  // and fills with the finished product bits.
  always_comb begin
    sum       = {1'b0, hi_r} + {1'b0, (lo_r[0] ? mcand_r : 32'd0)};
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      mcand_nxt = req.mcand;
      hi_nxt    = '0;
      lo_nxt    = req.mplier;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum[32:1];
      lo_nxt  = {sum[0], lo_r[31:1]};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == MUL_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; operand and product registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = {hi_r, lo_r};

endmodule

`default_nettype wire

@@ hdl/ddc_regs.sv @@
`default_nettype none

// Configuration registers behind the APB-style port.
module ddc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ddc_pkg::cfg_t                 cfg
);
  import ddc_pkg::*;

  cfg_t               cfg_r, cfg_nxt;
  logic [RegIdxW-1:0] idx;
  logic               wr_en;

  assign idx    = paddr[CfgAddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write decode; each register keeps only its own width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_TRACK_WIDTH:    cfg_nxt.track_width    = pwdata[19:0];
        REG_SPEED_LIMIT:    cfg_nxt.speed_limit    = pwdata[30:0];
        REG_LEFT_MOTOR_ID:  cfg_nxt.left_motor_id  = pwdata[28:0];
        REG_RIGHT_MOTOR_ID: cfg_nxt.right_motor_id = pwdata[28:0];
        REG_DUTY_GAIN:      cfg_nxt.duty_gain      = pwdata;
        REG_PERIOD_TICKS:   cfg_nxt.period_ticks   = pwdata[15:0];
        REG_TIMEOUT_TICKS:  cfg_nxt.timeout_ticks  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      REG_TRACK_WIDTH:    prdata = {12'd0, cfg_r.track_width};
      REG_SPEED_LIMIT:    prdata = {1'b0, cfg_r.speed_limit};
      REG_LEFT_MOTOR_ID:  prdata = {3'd0, cfg_r.left_motor_id};
      REG_RIGHT_MOTOR_ID: prdata = {3'd0, cfg_r.right_motor_id};
      REG_DUTY_GAIN:      prdata = cfg_r.duty_gain;
      REG_PERIOD_TICKS:   prdata = {16'd0, cfg_r.period_ticks};
      REG_TIMEOUT_TICKS:  prdata = {16'd0, cfg_r.timeout_ticks};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ hdl/ddc_seq.sv @@
`default_nettype none

// Command store, heartbeat and period tracking, and the control-step sequencer.
module ddc_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ddc_pkg::in_item_t   in_item,
  input  ddc_pkg::cfg_t       cfg,
  output ddc_pkg::mul_req_t   mul_req,
  input  ddc_pkg::mul_rsp_t   mul_rsp,
  input  logic                out_free,
  output ddc_pkg::push_t      push
);
  import ddc_pkg::*;

  seq_state_t         state_r, state_nxt;
  logic signed [31:0] lin_r, lin_nxt;
  logic signed [31:0] ang_r, ang_nxt;
  logic               seen_r, seen_nxt;
  logic [16:0]        age_r, age_nxt;
  logic [15:0]        pc_r, pc_nxt;
  logic [35:0]        half_r, half_nxt;
  logic signed [31:0] vl_r, vl_nxt;
  logic signed [31:0] vr_r, vr_nxt;
  logic [31:0]        duty_r, duty_nxt;

  logic               accept;
  logic [16:0]        age_inc;
  logic [15:0]        pc_inc;
  logic [15:0]        period;
  logic               step_due;
  logic               fresh;
  logic               run_step;

  logic signed [36:0] lin_ext, half_ext, half_sel, speed, max_ext;
  logic signed [31:0] speed_clamped;
  logic [34:0]        half_mag;
  logic [35:0]        half_wide;
  logic [31:0]        duty_mag;
  logic [16:0]        duty_sat;
  logic               duty_neg;

  function automatic logic [31:0] mag_of(input logic [31:0] v);
    mag_of = v[31] ? (32'd0 - v) : v;
  endfunction

  // Tick bookkeeping and the decision to run a control step.
  always_comb begin
    accept   = in_valid && (state_r == S_IDLE);
    age_inc  = (seen_r && (age_r != AGE_MAX)) ? (age_r + 17'd1) : age_r;
    pc_inc   = (pc_r != COUNT_MAX) ? (pc_r + 16'd1) : pc_r;
    period   = (cfg.period_ticks == 16'd0) ? 16'd1 : cfg.period_ticks;
    step_due = (pc_inc >= period);
    fresh    = seen_r && (age_inc <= {1'b0, cfg.timeout_ticks});
    run_step = accept && (in_item.action == ACT_TICK) && step_due && fresh;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (run_step) state_nxt = S_HALF;
      S_HALF:   if (mul_rsp.done) state_nxt = S_LEFT;
      S_LEFT:   state_nxt = S_RIGHT;
      S_RIGHT:  state_nxt = S_MUL_L;
      S_MUL_L:  if (mul_rsp.done) state_nxt = S_PUSH_L;
      S_PUSH_L: if (out_free) state_nxt = S_MUL_R;
      S_MUL_R:  if (mul_rsp.done) state_nxt = S_PUSH_R;
      S_PUSH_R: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs: handshake, multiplier requests and frame pushes.
  always_comb begin
    in_ready           = (state_r == S_IDLE);
    mul_req.start      = 1'b0;
    mul_req.mcand      = cfg.duty_gain;
    mul_req.mplier     = mag_of(vl_r);
    push.push          = 1'b0;
    push.frame.frame_id    = {3'd0, cfg.left_motor_id} | EFF_FLAG;
    push.frame.data_length = DATA_LEN;
    push.frame.payload     = {duty_r, 32'd0};
    push.frame.last_frame  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        mul_req.start  = run_step;
        mul_req.mcand  = mag_of(ang_r);
        mul_req.mplier = {12'd0, cfg.track_width};
      end
      S_RIGHT: begin
        mul_req.start  = 1'b1;
      end
      S_PUSH_L: begin
        mul_req.start  = out_free;
        mul_req.mplier = mag_of(vr_r);
        push.push      = out_free;
      end
      S_PUSH_R: begin
        push.push              = out_free;
        push.frame.frame_id    = {3'd0, cfg.right_motor_id} | EFF_FLAG;
        push.frame.last_frame  = 1'b1;
      end
      default: ;
    endcase
  end

  // Wheel speed: the stored linear speed minus or plus the half offset, clamped.
  always_comb begin
    lin_ext  = {{5{lin_r[31]}}, lin_r};
    half_ext = {half_r[35], half_r};
    half_sel = (state_r == S_LEFT) ? -half_ext : half_ext;
    speed    = lin_ext + half_sel;
    max_ext  = {6'd0, cfg.speed_limit};
    if (speed > max_ext) begin
      speed_clamped = {1'b0, cfg.speed_limit};
    end else if (speed < -max_ext) begin
      speed_clamped = 32'd0 - {1'b0, cfg.speed_limit};
    end else begin
      speed_clamped = speed[31:0];
    end
  end

  // Half offset and duty from the multiplier result.
  always_comb begin
    half_mag  = mul_rsp.product[51:17];
    half_wide = {1'b0, half_mag};
    duty_mag  = mul_rsp.product[63:32];
    duty_sat  = (duty_mag > {15'd0, DUTY_LIMIT}) ? DUTY_LIMIT : duty_mag[16:0];
    duty_neg  = (state_r == S_MUL_L) ? vl_r[31] : vr_r[31];
  end

  // Datapath register updates.
  always_comb begin
    lin_nxt  = lin_r;
    ang_nxt  = ang_r;
    seen_nxt = seen_r;
    age_nxt  = age_r;
    pc_nxt   = pc_r;
    half_nxt = half_r;
    vl_nxt   = vl_r;
    vr_nxt   = vr_r;
    duty_nxt = duty_r;
    if (accept) begin
      unique case (in_item.action)
        ACT_COMMAND: begin
          lin_nxt = in_item.linear_velocity;
          ang_nxt = in_item.angular_velocity;
        end
        ACT_HEARTBEAT: begin
          seen_nxt = 1'b1;
          age_nxt  = '0;
        end
        ACT_TICK: begin
          age_nxt = age_inc;
          pc_nxt  = step_due ? 16'd0 : pc_inc;
        end
        default: ;
      endcase
    end
    if ((state_r == S_HALF) && mul_rsp.done) begin
      half_nxt = ang_r[31] ? (36'd0 - half_wide) : half_wide;
    end
    if (state_r == S_LEFT) begin
      vl_nxt = speed_clamped;
    end
    if (state_r == S_RIGHT) begin
      vr_nxt = speed_clamped;
    end
    if (((state_r == S_MUL_L) || (state_r == S_MUL_R)) && mul_rsp.done) begin
      duty_nxt = duty_neg ? (32'd0 - {15'd0, duty_sat}) : {15'd0, duty_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lin_r   <= '0;
      ang_r   <= '0;
      seen_r  <= 1'b0;
      age_r   <= '0;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      lin_r   <= lin_nxt;
      ang_r   <= ang_nxt;
      seen_r  <= seen_nxt;
      age_r   <= age_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    half_r <= half_nxt;
    vl_r   <= vl_nxt;
    vr_r   <= vr_nxt;
    duty_r <= duty_nxt;
  end

`ifndef NO_ASSERTIONS
  // A multiplier result only turns up while the sequencer is waiting for one.
  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == S_HALF || state_r == S_MUL_L || state_r == S_MUL_R))
    else $error("multiplier result arrived outside a wait state");

  // The left wheel speed never exceeds the configured clamp.
  a_left_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == S_LEFT) |-> (mag_of(vl_r) <= {1'b0, $past(cfg.speed_limit)}))
    else $error("left wheel speed outside clamp");

  // Every duty put into a frame lies within the duty limit.
  a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    push.push |-> ($signed(push.frame.payload[63:32]) <= $signed({15'd0, DUTY_LIMIT}) &&
                   $signed(push.frame.payload[63:32]) >= -$signed({15'd0, DUTY_LIMIT})))
    else $error("duty outside limit");

  // Input stalls only because a control step has just begun.
  a_busy_starts_step: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> (state_r == S_HALF))
    else $error("sequencer left idle without starting a step");
`endif

endmodule

`default_nettype wire

@@ hdl/diff_drive_duty_can_commander.sv @@
`default_nettype none

// Differential-drive duty commander. Input beats carry a velocity command,
// a heartbeat or a base-time tick; every period_ticks ticks, while the
// heartbeat is fresh, the block turns the last command into left and right
// wheel duties and sends two extended-ID CAN frame beats, left motor first.
// Command, heartbeat and ticks that run no control step are accepted whenever the block is idle.
// A tick that runs a control step holds the input for three passes through
// the shared bit-serial multiplier (half wheel offset, left duty, right duty)
// plus the sequencing states, and longer if the output register is still
// waiting for the previous frame to be taken.
// A single output register lets the next input beat be accepted while the
// right-motor frame still waits. Registers sit at byte addresses 4*i and
// should be written only while the block is idle.
module diff_drive_duty_can_commander (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ddc_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ddc_pkg::out_frame_t           out_frame,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ddc_pkg::*;

  cfg_t       cfg;
  mul_req_t   mul_req;
  mul_rsp_t   mul_rsp;
  push_t      push;
  logic       out_free;
  logic       out_valid_r, out_valid_nxt;
  out_frame_t out_frame_r, out_frame_nxt;

  ddc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ddc_sermul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  ddc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cfg      (cfg),
    .mul_req  (mul_req),
    .mul_rsp  (mul_rsp),
    .out_free (out_free),
    .push     (push)
  );

  // Output register: takes a new frame when empty or being emptied this cycle.
  always_comb begin
    out_free      = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    out_frame_nxt = out_frame_r;
    if (push.push) begin
      out_valid_nxt = 1'b1;
      out_frame_nxt = push.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_frame_r <= out_frame_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_frame = out_frame_r;

endmodule

`default_nettype wire
